// File: design/tcss_pkg.sv
// Shared types, constants and the seven-segment table for the temperature
// compensation and display unit. No dependencies.
`timescale 1ns / 1ps

package tcss_pkg;

  // Calibration register indexes
  localparam logic [1:0] CFG_OFFSET = 2'd0;
  localparam logic [1:0] CFG_LINEAR = 2'd1;
  localparam logic [1:0] CFG_SQUARE = 2'd2;

  // Calibration reset values
  localparam logic [15:0] RST_OFFSET = 16'd27504;
  localparam logic [15:0] RST_LINEAR = 16'd26435;
  localparam logic [15:0] RST_SQUARE = 16'hFC18;  // -1000

  // Display range limit in hundredths of a degree
  localparam logic [17:0] OOR_LIMIT = 18'd10000;

  // Reciprocal multipliers: x / 100 = (x * 5243) >> 19 for x < 43699,
  // x / 10 = (x * 205) >> 11 for x < 1029
  localparam logic [25:0] DIV100_MUL = 26'd5243;
  localparam logic [14:0] DIV10_MUL  = 15'd205;

  localparam logic [7:0] SEG_BLANK = 8'h00;

  // Item latency from accept to result strobe
  localparam int LATENCY = 6;

  typedef struct packed {
    logic [7:0] raw_msb;
    logic [7:0] raw_lsb;
    logic [7:0] raw_xlsb;
  } sample_t;

  typedef struct packed {
    logic signed [18:0] temp_centi;
    logic [7:0]         seg_hundredths;
    logic [7:0]         seg_tenths;
    logic [7:0]         seg_units;
    logic [7:0]         seg_tens;
    logic               out_of_range;
  } result_t;

  typedef struct packed {
    logic [15:0]        offset;
    logic signed [15:0] linear;
    logic signed [15:0] square;
  } cal_t;

  // Compensated value handed from the arithmetic pipe to the digit pipe
  typedef struct packed {
    logic               valid;
    logic signed [18:0] centi;
    logic               oor;
  } fixed_t;

  // Seven-segment code of one decimal digit, bit 0 is segment a
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'b00111111;
      4'd1: code = 8'b00000110;
      4'd2: code = 8'b01011011;
      4'd3: code = 8'b01001111;
      4'd4: code = 8'b01100110;
      4'd5: code = 8'b01101101;
      4'd6: code = 8'b01111101;
      4'd7: code = 8'b00000111;
      4'd8: code = 8'b01111111;
      4'd9: code = 8'b01101111;
      default: code = SEG_BLANK;
    endcase
    return code;
  endfunction

endpackage

// File: design/temp_compensate_seven_segment_unit.sv
// An accepted transaction passes stages 1 to 4 in tcss_comp, then stages 5 and 6 in tcss_digits.
// Throughput: one transaction per cycle; busy never rises, since the six
// register stages (four of compensation, two of digit split) never stall.
// Reset: synchronous, clears all stage valid bits and loads the calibration
// defaults. Results cannot be held off by the receiver; done lasts one cycle.
`timescale 1ns / 1ps

module temp_compensate_seven_segment_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tcss_pkg::sample_t sample,
  output logic              done,
  output tcss_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  tcss_pkg::cal_t   cal;
  tcss_pkg::fixed_t fixed;
  logic             accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Calibration registers; writes to an unused index drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.offset <= tcss_pkg::RST_OFFSET;
      cal.linear <= tcss_pkg::RST_LINEAR;
      cal.square <= tcss_pkg::RST_SQUARE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcss_pkg::CFG_OFFSET: cal.offset <= cfg_data;
        tcss_pkg::CFG_LINEAR: cal.linear <= cfg_data;
        tcss_pkg::CFG_SQUARE: cal.square <= cfg_data;
        default: ;
      endcase
    end
  end

  tcss_comp u_comp (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .sample   (sample),
    .cal      (cal),
    .fixed    (fixed)
  );

  tcss_digits u_digits (
    .clk    (clk),
    .rst    (rst),
    .fixed  (fixed),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  // Every result strobe traces back to an accepted transaction
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, tcss_pkg::LATENCY))
    else $error("result strobe without accepted transaction");

  // Out-of-range results show blank digits
  a_blank_on_oor: assert property (@(posedge clk) disable iff (rst)
    (done && result.out_of_range) |->
      (result.seg_tens == tcss_pkg::SEG_BLANK) && (result.seg_units == tcss_pkg::SEG_BLANK) &&
      (result.seg_tenths == tcss_pkg::SEG_BLANK) &&
      (result.seg_hundredths == tcss_pkg::SEG_BLANK))
    else $error("digits not blanked when out of range");

  // In-range results are non-negative and show a lit tens digit
  a_in_range_lit: assert property (@(posedge clk) disable iff (rst)
    (done && !result.out_of_range) |->
      !result.temp_centi[18] && (result.seg_tens != tcss_pkg::SEG_BLANK))
    else $error("in-range result inconsistent");
`endif

endmodule

// File: design/tcss_comp.sv
// Four-stage compensation pipe: raw assembly, calibration multiplies and
// scaling to hundredths of a degree. Uses tcss_pkg.
`timescale 1ns / 1ps

module tcss_comp (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  tcss_pkg::sample_t sample,
  input  tcss_pkg::cal_t    cal,
  output tcss_pkg::fixed_t  fixed
);

  logic [19:0]        raw;
  logic signed [17:0] d1_next;
  logic signed [16:0] d2_next;
  logic [15:0]        ad2_next;

  logic               v1;
  logic signed [17:0] d1;
  logic [15:0]        ad2;

  logic signed [33:0] p1_next;
  logic [31:0]        sq_next;
  logic               v2;
  logic signed [33:0] p1;
  logic [31:0]        sq;

  logic signed [22:0] var1_next;
  logic signed [36:0] p2_next;
  logic               v3;
  logic signed [22:0] var1;
  logic signed [36:0] p2;

  logic signed [22:0] var2;
  logic signed [23:0] t_fine;
  logic signed [26:0] t5;
  logic signed [26:0] t_bias;
  logic signed [18:0] centi_next;
  logic               oor_next;

  // Stage 1: assemble the reading and take the offset differences
  assign raw      = {sample.raw_msb, sample.raw_lsb, sample.raw_xlsb[7:4]};
  assign d1_next  = $signed({1'b0, raw[19:3]}) - $signed({1'b0, cal.offset, 1'b0});
  assign d2_next  = $signed({1'b0, raw[19:4]}) - $signed({1'b0, cal.offset});
  assign ad2_next = d2_next[16] ? 16'(-d2_next) : d2_next[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    d1  <= d1_next;
    ad2 <= ad2_next;
  end

  // Stage 2: linear product and square of the second difference
  assign p1_next = d1 * cal.linear;
  assign sq_next = ad2 * ad2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    p1 <= p1_next;
    sq <= sq_next;
  end

  // Stage 3: floor-shift the linear term, scale the square by its gain
  assign var1_next = p1[33:11];
  assign p2_next   = $signed({1'b0, sq[31:12]}) * cal.square;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    var1 <= var1_next;
    p2   <= p2_next;
  end

  // Stage 4: fine value, times five, divide by 256 toward zero, range check
  assign var2       = p2[36:14];
  assign t_fine     = $signed({var1[22], var1}) + $signed({var2[22], var2});
  assign t5         = $signed({{3{t_fine[23]}}, t_fine}) + $signed({t_fine[23], t_fine, 2'b00});
  assign t_bias     = t5 + $signed({19'd0, {8{t5[26]}}});
  assign centi_next = t_bias[26:8];
  assign oor_next   = centi_next[18] || (centi_next[17:0] >= tcss_pkg::OOR_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed.valid <= 1'b0;
    end else begin
      fixed.valid <= v3;
    end
    fixed.centi <= centi_next;
    fixed.oor   <= oor_next;
  end

endmodule

// File: design/tcss_digits.sv
// Two-stage decimal split and seven-segment encoding with blanking.
// Uses tcss_pkg.
`timescale 1ns / 1ps

module tcss_digits (
  input  logic              clk,
  input  logic              rst,
  input  tcss_pkg::fixed_t  fixed,
  output logic              done,
  output tcss_pkg::result_t result
);

  logic [13:0]        c14;
  logic [25:0]        hp;
  logic [6:0]         hi_next;
  logic [6:0]         lo_next;

  logic               v5;
  logic signed [18:0] centi;
  logic               oor;
  logic [6:0]         hi;
  logic [6:0]         lo;

  logic [14:0]        hi_m;
  logic [14:0]        lo_m;
  logic [3:0]         d_tens;
  logic [3:0]         d_units;
  logic [3:0]         d_tenths;
  logic [3:0]         d_hundredths;

  // Stage 5: split into hundreds and the remainder below 100
  assign c14     = fixed.centi[13:0];
  assign hp      = 26'(c14) * tcss_pkg::DIV100_MUL;
  assign hi_next = hp[25:19];
  assign lo_next = c14[6:0] - hi_next * 7'd100;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= fixed.valid;
    end
    centi <= fixed.centi;
    oor   <= fixed.oor;
    hi    <= hi_next;
    lo    <= lo_next;
  end

  // Stage 6: split each pair into two digits and encode
  assign hi_m         = 15'(hi) * tcss_pkg::DIV10_MUL;
  assign lo_m         = 15'(lo) * tcss_pkg::DIV10_MUL;
  assign d_tens       = hi_m[14:11];
  assign d_units      = hi[3:0] - d_tens * 4'd10;
  assign d_tenths     = lo_m[14:11];
  assign d_hundredths = lo[3:0] - d_tenths * 4'd10;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v5;
    end
    result.temp_centi   <= centi;
    result.out_of_range <= oor;
    if (oor) begin
      result.seg_hundredths <= tcss_pkg::SEG_BLANK;
      result.seg_tenths     <= tcss_pkg::SEG_BLANK;
      result.seg_units      <= tcss_pkg::SEG_BLANK;
      result.seg_tens       <= tcss_pkg::SEG_BLANK;
    end else begin
      result.seg_hundredths <= tcss_pkg::seg_code(d_hundredths);
      result.seg_tenths     <= tcss_pkg::seg_code(d_tenths);
      result.seg_units      <= tcss_pkg::seg_code(d_units);
      result.seg_tens       <= tcss_pkg::seg_code(d_tens);
    end
  end

endmodule
